/* hdl/lnu_pkg.sv */
`default_nettype none
package lnu_pkg;
    localparam int MAX_CHUNK_DEF  = 64;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int CFG_WIDTH      = 32;
    localparam int CFG_IDX_WIDTH  = 1;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_CHUNK_LEN = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_EPSILON   = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MEAN,
        ST_VRD,
        ST_VACC,
        ST_VDIV,
        ST_RSQ,
        ST_ORD,
        ST_OMUL1,
        ST_OMUL2,
        ST_OEMIT
    } lnu_state_t;
endpackage
`default_nettype wire

/* hdl/lnu_ram.sv */
`default_nettype none
module lnu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/lnu_divu.sv */
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle.
module lnu_divu #(
    parameter int NW = 40,
    parameter int DW = 8
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           go,
    input  wire  [NW-1:0] num,
    input  wire  [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quot_reg, quot_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DW-1:0], quot_reg[NW-1]};
        if (go)
        begin
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg[DW-1:0];
endmodule
`default_nettype wire

/* hdl/lnu_rsqrt.sv */
`default_nettype none
// r = floor(2^31 / sqrt(v)): largest r with r*r*v <= 2^62, one bit per pass.
// Each bit passes through the square, the low half of the product with v,
// the high half of the product with v, then compare and keep.
module lnu_rsqrt (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         go,
    input  wire  [32:0] v,
    output logic        done,
    output logic [31:0] r
);
    logic [31:0] r_reg, r_next;
    logic [32:0] v_reg, v_next;
    logic [4:0]  bit_reg, bit_next;
    logic [1:0]  ph_reg, ph_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] sq_reg, sq_next;
    logic [64:0] lo_reg, lo_next;
    logic [64:0] hi_reg, hi_next;
    logic [31:0] cand;
    logic [96:0] total;

    assign cand  = r_reg | (32'd1 << bit_reg);
    // square times v, rebuilt from the two 32 x 33 partial products
    assign total = {hi_reg, 32'd0} + {32'd0, lo_reg};

    always_comb
    begin
        r_next    = r_reg;
        v_next    = v_reg;
        bit_next  = bit_reg;
        ph_next   = ph_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sq_next   = sq_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        if (go)
        begin
            r_next    = '0;
            v_next    = (v == 33'd0) ? 33'd1 : v;
            bit_next  = 5'd31;
            ph_next   = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (ph_reg)
                2'd0:
                begin
                    sq_next = {32'd0, cand} * {32'd0, cand};
                    ph_next = 2'd1;
                end
                2'd1:
                begin
                    lo_next = 65'(sq_reg[31:0]) * 65'(v_reg);
                    ph_next = 2'd2;
                end
                2'd2:
                begin
                    hi_next = 65'(sq_reg[63:32]) * 65'(v_reg);
                    ph_next = 2'd3;
                end
                default:
                begin
                    if (total <= (97'd1 << 62))
                    begin
                        r_next = cand;
                    end
                    ph_next = 2'd0;
                    bit_next = bit_reg - 1'b1;
                    if (bit_reg == 5'd0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ph_reg   <= 2'd0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ph_reg   <= ph_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        v_reg  <= v_next;
        sq_reg <= sq_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign done = done_reg;
    assign r    = r_reg;
endmodule
`default_nettype wire

/* hdl/layer_normalization_unit.sv */
`default_nettype none
// Row elements are taken only while idle; the element that ends a row
// starts a row pass: mean divide, variance read, variance divide, rsqrt,
// then a read, the multiplies and the emit step for each result.
// No new element is taken until the pass ends; the pass is paced by
// the row buffer port, the serial divider and rsqrt.
// Results cannot be stalled.
// Reset clears control state, counters and sums and loads config defaults;
// datapath registers and buffers are not cleared.
module layer_normalization_unit #(
    parameter int MAX_CHUNK  = lnu_pkg::MAX_CHUNK_DEF,
    parameter int DATA_WIDTH = lnu_pkg::DATA_WIDTH_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  signed [DATA_WIDTH-1:0]     sample,
    input  wire  signed [DATA_WIDTH-1:0]     gain,
    input  wire  signed [DATA_WIDTH-1:0]     offset,
    input  wire                              cfg_we,
    input  wire  [lnu_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire  [lnu_pkg::CFG_WIDTH-1:0]    cfg_data,
    output logic                             strobe,
    output logic signed [DATA_WIDTH-1:0]     normalized,
    output logic                             last,
    output logic                             saturated
);
    import lnu_pkg::*;

    localparam int AW  = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
    localparam int NW  = $clog2(MAX_CHUNK + 1);
    localparam int SW  = DATA_WIDTH + NW + 1;        // sum width
    localparam int DVW = DATA_WIDTH + 1;             // deviation width
    localparam int QW  = 2 * DVW + NW;               // square sum width
    localparam int DNW = QW;                         // divide width
    localparam int PW  = DVW + 32 + DATA_WIDTH + 1;  // product width

    lnu_state_t state_reg, state_next;

    logic [6:0]          len_reg;
    logic [31:0]         eps_reg;
    logic [NW-1:0]       fill_reg, fill_next;
    logic [NW-1:0]       n_reg, n_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [QW-1:0]       sq_reg, sq_next;
    logic [AW-1:0]       rd_reg, rd_next;
    logic                rdv_reg, rdv_next;
    logic signed [DVW-1:0] mean_reg, mean_next;
    logic [31:0]         r_reg;
    logic signed [DVW+32:0] p1_reg, p1_next;
    logic signed [PW-1:0]   p2_reg, p2_next;
    logic signed [DATA_WIDTH-1:0] off_reg, off_next;
    logic                lastp_reg, lastp_next;
    logic                strobe_reg;
    logic signed [DATA_WIDTH-1:0] out_reg;
    logic                last_reg, sat_reg;

    logic [NW-1:0]       len_eff;
    logic [AW-1:0]       idx, waddr, raddr;
    logic [NW-1:0]       n_in;
    logic                row_end;
    logic signed [SW-1:0] sum_in;
    logic                we;
    logic [DATA_WIDTH-1:0] s_rd, g_rd, o_rd;
    logic signed [DVW-1:0] dev;
    logic signed [2*DVW-1:0] dev_sq;

    logic                div_go;
    logic [DNW-1:0]      div_num;
    logic [DNW-1:0]      div_q;
    logic [NW:0]         div_den, div_rem;
    logic                div_done;
    logic                rs_go, rs_done;
    logic [32:0]         rs_v;
    logic [31:0]         rs_r;
    logic                accept;
    logic signed [PW+1:0] y_full;
    logic signed [PW+1:0] hi, lo;
    logic signed [PW+1:0] yv;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_LOAD);

    // clamp chunk length into 1..MAX_CHUNK
    always_comb
    begin
        if (len_reg == 7'd0)
        begin
            len_eff = NW'(1);
        end
        else if ({25'd0, len_reg} > MAX_CHUNK)
        begin
            len_eff = NW'(MAX_CHUNK);
        end
        else
        begin
            len_eff = NW'(len_reg);
        end
        idx = (fill_reg >= NW'(MAX_CHUNK)) ? AW'(MAX_CHUNK - 1) : fill_reg[AW-1:0];
    end

    // incoming beat: count, running sum, row end
    assign n_in    = NW'(idx) + 1'b1;
    assign row_end = (n_in >= len_eff);
    assign sum_in  = sum_reg + SW'(sample);

    assign we    = accept;
    assign waddr = idx;
    assign raddr = rd_reg;

    lnu_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_CHUNK)) u_sample_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(sample), .raddr(raddr), .rdata(s_rd)
    );
    lnu_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_CHUNK)) u_gain_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(gain), .raddr(raddr), .rdata(g_rd)
    );
    lnu_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_CHUNK)) u_offset_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(offset), .raddr(raddr), .rdata(o_rd)
    );

    // shared serial divider: mean, then variance
    lnu_divu #(.NW(DNW), .DW(NW + 1)) u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
        .done(div_done), .quot(div_q), .rem(div_rem)
    );

    lnu_rsqrt u_rsqrt (
        .clk(clk), .rst_n(rst_n), .go(rs_go), .v(rs_v), .done(rs_done), .r(rs_r)
    );

    assign dev    = DVW'($signed(s_rd)) - mean_reg;
    assign dev_sq = dev * dev;

    assign y_full = (p2_reg + (PW'(1) << 34)) >>> 35;
    assign yv     = y_full + (PW + 2)'(off_reg);
    assign hi     = (PW + 2)'((1 << (DATA_WIDTH - 1)) - 1);
    assign lo     = -(PW + 2)'(1 << (DATA_WIDTH - 1));

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (accept && row_end) state_next = ST_MEAN;
            ST_MEAN:  if (div_done) state_next = ST_VRD;
            ST_VRD:   state_next = ST_VACC;
            ST_VACC:  if (!rdv_reg) state_next = ST_VDIV;
            ST_VDIV:  if (div_done) state_next = ST_RSQ;
            ST_RSQ:   if (rs_done) state_next = ST_ORD;
            ST_ORD:   state_next = ST_OMUL1;
            ST_OMUL1: state_next = ST_OMUL2;
            ST_OMUL2: state_next = ST_OEMIT;
            ST_OEMIT: state_next = lastp_reg ? ST_LOAD : ST_ORD;
            default:  state_next = ST_LOAD;
        endcase
    end

    // datapath controls
    always_comb
    begin
        fill_next  = fill_reg;
        n_next     = n_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        rd_next    = rd_reg;
        rdv_next   = 1'b0;
        mean_next  = mean_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        off_next   = off_reg;
        lastp_next = lastp_reg;
        div_go     = 1'b0;
        div_num    = '0;
        div_den    = {1'b0, n_reg};
        rs_go      = 1'b0;
        rs_v       = 33'(sq_reg) + 33'(eps_reg);
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    sum_next = sum_in;
                    if (row_end)
                    begin
                        n_next    = n_in;
                        fill_next = '0;
                        div_go    = 1'b1;
                        // floor((2*sum + n) / (2n)), biased by 2^(DATA_WIDTH-1)
                        // in the quotient to keep the numerator positive
                        div_num   = (DNW'(sum_in) << 1) + DNW'(n_in)
                                  + (DNW'(n_in) << DATA_WIDTH);
                        div_den   = {n_in, 1'b0};
                    end
                    else
                    begin
                        fill_next = n_in;
                    end
                end
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    mean_next = DVW'(div_q - (DNW'(1) << (DATA_WIDTH - 1)));
                    rd_next   = '0;
                    sq_next   = '0;
                end
            end
            ST_VRD:
            begin
                rdv_next = 1'b1;
                rd_next  = (n_reg > NW'(1)) ? AW'(1) : '0;
            end
            ST_VACC:
            begin
                if (rdv_reg)
                begin
                    sq_next = sq_reg + QW'(unsigned'(dev_sq));
                    if (NW'(rd_reg) < n_reg - 1'b1 && rd_reg != '0)
                    begin
                        rdv_next = 1'b1;
                        rd_next  = rd_reg + 1'b1;
                    end
                    else if (rd_reg != '0 && NW'(rd_reg) == n_reg - 1'b1)
                    begin
                        rdv_next = 1'b1;
                        rd_next  = '0;
                    end
                end
                if (!rdv_reg)
                begin
                    div_go  = 1'b1;
                    div_num = DNW'(sq_reg);
                end
            end
            ST_VDIV:
            begin
                if (div_done)
                begin
                    rs_go = 1'b1;
                    rs_v  = 33'(div_q) + 33'(eps_reg);
                    rd_next = '0;
                end
            end
            ST_ORD:
            begin
                lastp_next = (NW'(rd_reg) == n_reg - 1'b1);
            end
            ST_OMUL1:
            begin
                p1_next  = (DVW + 33)'(dev) * $signed({1'b0, r_reg});
                off_next = $signed(o_rd);
                p2_next  = PW'($signed(g_rd));
            end
            ST_OMUL2:
            begin
                p2_next = PW'(p1_reg) * p2_reg;
            end
            ST_OEMIT:
            begin
                rd_next = rd_reg + 1'b1;
                if (lastp_reg)
                begin
                    sum_next = '0;
                    sq_next  = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            len_reg    <= 7'd64;
            eps_reg    <= 32'd1;
            fill_reg   <= '0;
            n_reg      <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            rd_reg     <= '0;
            rdv_reg    <= 1'b0;
            strobe_reg <= 1'b0;
            lastp_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            n_reg      <= n_next;
            sum_reg    <= sum_next;
            sq_reg     <= (state_reg == ST_VDIV && div_done) ? QW'(div_q) : sq_next;
            rd_reg     <= rd_next;
            rdv_reg    <= rdv_next;
            lastp_reg  <= lastp_next;
            strobe_reg <= (state_reg == ST_OEMIT);
            if (cfg_we && cfg_index == REG_CHUNK_LEN)
            begin
                len_reg <= cfg_data[6:0];
            end
            if (cfg_we && cfg_index == REG_EPSILON)
            begin
                eps_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        off_reg  <= off_next;
        if (rs_done)
        begin
            r_reg <= rs_r;
        end
        if (state_reg == ST_OEMIT)
        begin
            last_reg <= lastp_reg;
            if (yv > hi)
            begin
                out_reg <= DATA_WIDTH'(hi);
                sat_reg <= 1'b1;
            end
            else if (yv < lo)
            begin
                out_reg <= DATA_WIDTH'(lo);
                sat_reg <= 1'b1;
            end
            else
            begin
                out_reg <= DATA_WIDTH'(yv);
                sat_reg <= 1'b0;
            end
        end
    end

    assign strobe     = strobe_reg;
    assign normalized = out_reg;
    assign last       = last_reg;
    assign saturated  = sat_reg;
endmodule
`default_nettype wire

/* hdl/lnu_checker.sv */
`default_nettype none
module lnu_checker (
    input wire clk,
    input wire rst_n,
    input wire start,
    input wire busy,
    input wire strobe,
    input wire last
);
    // results only appear while a row pass is running
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy)) else $error("result outside row pass");
    // a beat that is not final leaves the row pass running
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy) else $error("idle before final beat");
    // results are spaced by the output loop
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe) else $error("back to back results");
    // block is already idle when the final beat shows
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy) else $error("busy after last beat");
endmodule

bind layer_normalization_unit lnu_checker u_lnu_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .strobe(strobe), .last(last)
);
`default_nettype wire
